[src/wmmmv_pkg.sv]
// Package: shared widths, constants and the divider status type.
`default_nettype none
package wmmmv_pkg;

   localparam int DATA_W            = 32;
   localparam int ACC_W             = 64;
   localparam int FRAC_W            = 16;
   localparam int DIV_STEPS         = 32;
   localparam int DEFAULT_MAX_ITEMS = 1024;

   localparam logic [DATA_W-1:0] ONE_Q16 = 32'h0001_0000;
   localparam logic [DATA_W-1:0] TOP32   = 32'hFFFF_FFFF;

   typedef struct packed {
      logic busy;
      logic done;
   } div_sts_type;

endpackage
`default_nettype wire

[src/wmmmv_divider.sv]
// Iterative Q16.16 divider: floor(numer * 2^16 / denom), saturated to 32 bits.
`default_nettype none
module wmmmv_divider
   import wmmmv_pkg::*;
#(
   parameter int DEN_W = 43
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic [ACC_W-1:0]    numer,
   input  wire logic [DEN_W-1:0]    denom,
   output div_sts_type              sts,
   output logic      [DATA_W-1:0]   quot
);

   localparam int STEP_W = $clog2(DIV_STEPS);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [DEN_W-1:0]    rem_ff, rem_in;
   logic [DEN_W-1:0]    den_ff, den_in;
   logic [DATA_W-1:0]   dvd_ff, dvd_in;
   logic [DATA_W-1:0]   quot_ff, quot_in;

   logic [ACC_W:0]      den_shift;
   logic [DEN_W:0]      trial;
   logic                fits;

   always_comb begin
      den_shift = (ACC_W+1)'(denom) << FRAC_W;
      trial     = {rem_ff, dvd_ff[DATA_W-1]};
      fits      = trial >= {1'b0, den_ff};

      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      dvd_in  = dvd_ff;
      quot_in = quot_ff;

      if (start) begin
         den_in = denom;
         if ({1'b0, numer} >= den_shift) begin
            // quotient would not fit in 32 bits: saturate
            quot_in = TOP32;
            done_in = 1'b1;
         end else begin
            rem_in  = DEN_W'(numer >> FRAC_W);
            dvd_in  = {numer[FRAC_W-1:0], {(DATA_W-FRAC_W){1'b0}}};
            step_in = STEP_W'(DIV_STEPS - 1);
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         rem_in  = fits ? DEN_W'(trial - {1'b0, den_ff}) : trial[DEN_W-1:0];
         quot_in = {quot_ff[DATA_W-2:0], fits};
         dvd_in  = {dvd_ff[DATA_W-2:0], 1'b0};
         step_in = step_ff - STEP_W'(1);
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      dvd_ff  <= dvd_in;
      quot_ff <= quot_in;
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign quot     = quot_ff;

endmodule
`default_nettype wire

[src/weighted_min_max_mean_variance_unit.sv]
// Top level: weighted minimum, maximum, mean and variance over a stored set.
// Sequence: a word without set end is taken while loading. After a set end the unit
//   settles, runs the divider for the mean (start, steps, done; no steps if the quotient
//   saturates), makes the second pass over the sample memory, runs the divider for the
//   variance and loads the result register. An empty set goes straight to the result.
// Throughput: one input word per cycle while loading; one set at a time.
// Reset: synchronous, active high; clears control and statistics, use_weights to 1.
`default_nettype none
module weighted_min_max_mean_variance_unit
   import wmmmv_pkg::*;
#(
   parameter int MAX_ITEMS = DEFAULT_MAX_ITEMS
) (
   input  wire logic              clock,
   input  wire logic              reset,
   // input words
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [DATA_W-1:0] req_value,
   input  wire logic [DATA_W-1:0] req_weight,
   input  wire logic              req_carries_value,
   input  wire logic              req_ends_set,
   // result words
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic      [DATA_W-1:0] rsp_minimum,
   output logic      [DATA_W-1:0] rsp_maximum,
   output logic      [DATA_W-1:0] rsp_mean,
   output logic      [DATA_W-1:0] rsp_variance,
   output logic                   rsp_set_empty,
   // configuration
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic              csr_use_weights
);

   localparam int CNT_W = $clog2(MAX_ITEMS + 1);
   localparam int IDX_W = $clog2(MAX_ITEMS);
   localparam int TOT_W = DATA_W + CNT_W;
   localparam int SQ_W  = ACC_W - FRAC_W;

   typedef enum logic [2:0] {
      ST_LOAD, ST_SETTLE, ST_MEAN_GO, ST_MEAN_WAIT,
      ST_PASS, ST_VAR_GO, ST_VAR_WAIT, ST_DONE
   } state_type;

   state_type           state_ff;
   logic                use_weights_ff;

   // running statistics
   logic [CNT_W-1:0]    count_ff;
   logic [ACC_W-1:0]    wsum_ff;
   logic [TOT_W-1:0]    total_ff;
   logic [DATA_W-1:0]   min_ff, max_ff;
   logic [ACC_W-1:0]    vsum_ff;
   logic [ACC_W-1:0]    prod_ff;
   logic                prod_vld_ff;
   logic [DATA_W-1:0]   mean_ff, var_ff;

   // sample memory: value in the upper half, effective weight in the lower
   logic [2*DATA_W-1:0] mem [MAX_ITEMS];
   logic [2*DATA_W-1:0] mem_rd_ff;

   // second pass pipeline
   logic [CNT_W-1:0]    rd_ptr_ff;
   logic                v1_ff, v2_ff, v3_ff, v4_ff;
   logic [ACC_W-1:0]    dd_ff;
   logic [DATA_W-1:0]   wt2_ff;
   logic [ACC_W-1:0]    plo_ff;
   logic [SQ_W-1:0]     sq3_ff;
   logic [FRAC_W-1:0]   wh3_ff;
   logic [ACC_W-1:0]    term_ff;

   // result register
   logic                rsp_valid_ff;
   logic [DATA_W-1:0]   rsp_min_ff, rsp_max_ff, rsp_mean_ff, rsp_var_ff;
   logic                rsp_empty_ff;

   // divider
   logic                div_start;
   logic [ACC_W-1:0]    div_numer;
   div_sts_type         div_sts;
   logic [DATA_W-1:0]   div_quot;

   logic                req_fire, take_value, mem_we, issue, pass_idle, load_rsp;
   logic [DATA_W-1:0]   w_eff, x_rd, w_rd, dev;
   logic [ACC_W:0]      vsum_wide;

   assign req_ready = (state_ff == ST_LOAD);
   assign csr_ready = 1'b1;
   assign req_fire  = req_valid && req_ready;

   // drop values once the store is full
   assign take_value = req_fire && req_carries_value && (count_ff < CNT_W'(MAX_ITEMS));
   assign mem_we     = take_value;
   assign w_eff      = use_weights_ff ? req_weight : ONE_Q16;

   assign issue     = (state_ff == ST_PASS) && (rd_ptr_ff < count_ff);
   assign pass_idle = (rd_ptr_ff == count_ff) && !v1_ff && !v2_ff && !v3_ff && !v4_ff;
   assign load_rsp  = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   assign x_rd = mem_rd_ff[2*DATA_W-1:DATA_W];
   assign w_rd = mem_rd_ff[DATA_W-1:0];
   assign dev  = (x_rd >= mean_ff) ? (x_rd - mean_ff) : (mean_ff - x_rd);

   // saturating accumulate of the deviation terms
   assign vsum_wide = {1'b0, vsum_ff} + {1'b0, term_ff};

   assign div_start = (state_ff == ST_MEAN_GO) || (state_ff == ST_VAR_GO);
   assign div_numer = (state_ff == ST_MEAN_GO) ? wsum_ff : vsum_ff;

   wmmmv_divider #(
      .DEN_W (TOT_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (div_numer),
      .denom (total_ff),
      .sts   (div_sts),
      .quot  (div_quot)
   );

   // sample memory: one write port while loading, one read port for the pass
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[count_ff[IDX_W-1:0]] <= {req_value, w_eff};
      end
      mem_rd_ff <= mem[rd_ptr_ff[IDX_W-1:0]];
   end

   // pass datapath: square, low product, term; also the loading product of value and weight
   always_ff @(posedge clock) begin
      dd_ff   <= ACC_W'(dev) * ACC_W'(dev);
      wt2_ff  <= w_rd;
      plo_ff  <= ACC_W'(dd_ff[ACC_W-1:FRAC_W]) * ACC_W'(wt2_ff[FRAC_W-1:0]);
      sq3_ff  <= dd_ff[ACC_W-1:FRAC_W];
      wh3_ff  <= wt2_ff[DATA_W-1:FRAC_W];
      term_ff <= ACC_W'(sq3_ff) * ACC_W'(wh3_ff) + (plo_ff >> FRAC_W);
      prod_ff <= ACC_W'(req_value) * ACC_W'(w_eff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_LOAD;
         use_weights_ff <= 1'b1;
         count_ff       <= '0;
         wsum_ff        <= '0;
         total_ff       <= '0;
         min_ff         <= TOP32;
         max_ff         <= '0;
         vsum_ff        <= '0;
         prod_vld_ff    <= 1'b0;
         rd_ptr_ff      <= '0;
         v1_ff          <= 1'b0;
         v2_ff          <= 1'b0;
         v3_ff          <= 1'b0;
         v4_ff          <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         rsp_min_ff     <= '0;
         rsp_max_ff     <= '0;
         rsp_mean_ff    <= '0;
         rsp_var_ff     <= '0;
         rsp_empty_ff   <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            use_weights_ff <= csr_use_weights;
         end

         // product lands in the cycle after the word; add its Q16.16 part
         prod_vld_ff <= take_value;
         if (prod_vld_ff) begin
            wsum_ff <= wsum_ff + ACC_W'(prod_ff[ACC_W-1:FRAC_W]);
         end

         if (take_value) begin
            count_ff <= count_ff + CNT_W'(1);
            total_ff <= total_ff + TOT_W'(w_eff);
            if (req_value < min_ff) begin
               min_ff <= req_value;
            end
            if (req_value > max_ff) begin
               max_ff <= req_value;
            end
         end

         v1_ff <= issue;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         if (issue) begin
            rd_ptr_ff <= rd_ptr_ff + CNT_W'(1);
         end
         if (v4_ff) begin
            vsum_ff <= vsum_wide[ACC_W] ? {ACC_W{1'b1}} : vsum_wide[ACC_W-1:0];
         end

         // raise on a new result, drop once the old one is taken
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_LOAD: begin
               if (req_fire && req_ends_set) begin
                  state_ff <= ST_SETTLE;
               end
            end
            ST_SETTLE: begin
               // last product is added this cycle
               rd_ptr_ff <= '0;
               if (count_ff == '0) begin
                  state_ff <= ST_DONE;
               end else if (total_ff == '0) begin
                  mean_ff  <= (wsum_ff > ACC_W'(TOP32)) ? TOP32 : wsum_ff[DATA_W-1:0];
                  state_ff <= ST_PASS;
               end else begin
                  state_ff <= ST_MEAN_GO;
               end
            end
            ST_MEAN_GO: begin
               state_ff <= ST_MEAN_WAIT;
            end
            ST_MEAN_WAIT: begin
               if (div_sts.done) begin
                  mean_ff  <= div_quot;
                  state_ff <= ST_PASS;
               end
            end
            ST_PASS: begin
               if (pass_idle) begin
                  if (total_ff == '0) begin
                     var_ff   <= (vsum_ff > ACC_W'(TOP32)) ? TOP32 : vsum_ff[DATA_W-1:0];
                     state_ff <= ST_DONE;
                  end else begin
                     state_ff <= ST_VAR_GO;
                  end
               end
            end
            ST_VAR_GO: begin
               state_ff <= ST_VAR_WAIT;
            end
            ST_VAR_WAIT: begin
               if (div_sts.done) begin
                  var_ff   <= div_quot;
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               // hold until the result register is free, then load it and clear the set
               if (load_rsp) begin
                  if (count_ff == '0) begin
                     rsp_min_ff   <= '0;
                     rsp_max_ff   <= '0;
                     rsp_mean_ff  <= '0;
                     rsp_var_ff   <= '0;
                     rsp_empty_ff <= 1'b1;
                  end else begin
                     rsp_min_ff   <= min_ff;
                     rsp_max_ff   <= max_ff;
                     rsp_mean_ff  <= mean_ff;
                     rsp_var_ff   <= var_ff;
                     rsp_empty_ff <= 1'b0;
                  end
                  count_ff     <= '0;
                  wsum_ff      <= '0;
                  total_ff     <= '0;
                  min_ff       <= TOP32;
                  max_ff       <= '0;
                  vsum_ff      <= '0;
                  state_ff     <= ST_LOAD;
               end
            end
            default: begin
               state_ff <= ST_LOAD;
            end
         endcase
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_minimum   = rsp_min_ff;
   assign rsp_maximum   = rsp_max_ff;
   assign rsp_mean      = rsp_mean_ff;
   assign rsp_variance  = rsp_var_ff;
   assign rsp_set_empty = rsp_empty_ff;

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_ITEMS))
      else $error("item count beyond store depth");

   a_load_no_div: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !div_sts.busy)
      else $error("words taken while divider runs");

   a_pass_no_write: assert property (@(posedge clock) disable iff (reset)
      issue |-> !mem_we)
      else $error("store written during second pass");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load_rsp |-> (!rsp_valid_ff || rsp_ready))
      else $error("pending result overwritten");

   a_div_done_waited: assert property (@(posedge clock) disable iff (reset)
      div_sts.done |-> (state_ff == ST_MEAN_WAIT || state_ff == ST_VAR_WAIT))
      else $error("divider result with nobody waiting");
`endif

endmodule
`default_nettype wire

[tb/weighted_min_max_mean_variance_checker.sv]
// Checker: predicts the statistics of each set and compares the result words.
`default_nettype none
module weighted_min_max_mean_variance_checker
   import wmmmv_pkg::*;
#(
   parameter int MAX_ITEMS = DEFAULT_MAX_ITEMS
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic              req_ready,
   input  wire logic [DATA_W-1:0] req_value,
   input  wire logic [DATA_W-1:0] req_weight,
   input  wire logic              req_carries_value,
   input  wire logic              req_ends_set,
   input  wire logic              rsp_valid,
   input  wire logic              rsp_ready,
   input  wire logic [DATA_W-1:0] rsp_minimum,
   input  wire logic [DATA_W-1:0] rsp_maximum,
   input  wire logic [DATA_W-1:0] rsp_mean,
   input  wire logic [DATA_W-1:0] rsp_variance,
   input  wire logic              rsp_set_empty,
   input  wire logic              csr_valid,
   input  wire logic              csr_ready,
   input  wire logic              csr_use_weights,
   output int                     fail_count,
   output int                     stats_pending,
   output int                     stats_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      bit [31:0] minimum;
      bit [31:0] maximum;
      bit [31:0] mean;
      bit [31:0] variance;
      bit        set_empty;
   } set_stats_type;

   set_stats_type stats_queue[$];
   bit            weights_on;
   bit [31:0]     sample_values[MAX_ITEMS];
   bit [31:0]     sample_weights[MAX_ITEMS];
   int unsigned   stored_count;
   bit [63:0]     weighted_total;
   bit [63:0]     weight_total;
   bit [31:0]     low_mark;
   bit [31:0]     high_mark;
   int            fails = 0;
   int            checked = 0;

   // floor(num * 2^16 / den), saturated to 32 bits
   function automatic bit [31:0] q16_quotient(bit [63:0] num, bit [63:0] den);
      bit [63:0] q;
      bit [63:0] r;
      q = num / den;
      r = num % den;
      if (q >= 64'h1_0000) return TOP32;
      return 32'((q << 16) + ((r << 16) / den));
   endfunction

   function automatic bit [31:0] clip32(bit [63:0] x);
      return (x > 64'(TOP32)) ? TOP32 : x[31:0];
   endfunction

   task automatic clear_set();
      stored_count   = 0;
      weighted_total = '0;
      weight_total   = '0;
      low_mark       = TOP32;
      high_mark      = '0;
   endtask

   // absorb one input word; queue a result when it closes the set
   task automatic absorb_word(bit [31:0] v, bit [31:0] w, bit carries, bit ends);
      set_stats_type s;
      bit [63:0]  spread;
      bit [63:0]  d;
      bit [63:0]  sq;
      bit [63:0]  term;
      bit [31:0]  m;
      if (carries && stored_count < MAX_ITEMS) begin
         if (!weights_on) w = ONE_Q16;
         sample_values[stored_count]  = v;
         sample_weights[stored_count] = w;
         stored_count++;
         if (v < low_mark) low_mark = v;
         if (v > high_mark) high_mark = v;
         weighted_total += (64'(v) * 64'(w)) >> 16;
         weight_total   += 64'(w);
      end
      if (!ends) return;
      if (stored_count == 0) begin
         s = '{minimum: 0, maximum: 0, mean: 0, variance: 0, set_empty: 1'b1};
      end else begin
         m = (weight_total != 0) ? q16_quotient(weighted_total, weight_total)
                                 : clip32(weighted_total);
         spread = '0;
         for (int i = 0; i < stored_count; i++) begin
            d    = (sample_values[i] >= m) ? 64'(sample_values[i] - m)
                                           : 64'(m - sample_values[i]);
            sq   = (d * d) >> 16;
            term = sq * 64'(sample_weights[i] >> 16)
                 + ((sq * 64'(sample_weights[i][15:0])) >> 16);
            spread = (spread > ~64'd0 - term) ? ~64'd0 : spread + term;
         end
         s.minimum   = low_mark;
         s.maximum   = high_mark;
         s.mean      = m;
         s.variance  = (weight_total != 0) ? q16_quotient(spread, weight_total)
                                           : clip32(spread);
         s.set_empty = 1'b0;
      end
      stats_queue = {stats_queue, s};
      clear_set();
   endtask

   always @(posedge clock) begin
      set_stats_type e;
      if (reset) begin
         weights_on = 1'b1;
         stats_queue.delete();
         clear_set();
      end else begin
         if (csr_valid && csr_ready) weights_on = csr_use_weights;
         if (rsp_valid && rsp_ready) begin
            if (stats_queue.size() == 0) begin
               $error("result word with no set waiting");
               fails++;
            end else begin
               e = stats_queue.pop_front();
               checked++;
               if (rsp_minimum !== e.minimum) begin
                  $error("minimum: expected %h, got %h", e.minimum, rsp_minimum);
                  fails++;
               end
               if (rsp_maximum !== e.maximum) begin
                  $error("maximum: expected %h, got %h", e.maximum, rsp_maximum);
                  fails++;
               end
               if (rsp_mean !== e.mean) begin
                  $error("mean: expected %h, got %h", e.mean, rsp_mean);
                  fails++;
               end
               if (rsp_variance !== e.variance) begin
                  $error("variance: expected %h, got %h", e.variance, rsp_variance);
                  fails++;
               end
               if (rsp_set_empty !== e.set_empty) begin
                  $error("set_empty: expected %b, got %b", e.set_empty, rsp_set_empty);
                  fails++;
               end
            end
         end
         if (req_valid && req_ready)
            absorb_word(req_value, req_weight, req_carries_value, req_ends_set);
      end
      fail_count    <= fails;
      stats_pending <= stats_queue.size();
      stats_checked <= checked;
   end
endmodule
`default_nettype wire

[tb/weighted_min_max_mean_variance_unit_tb.sv]
// Testbench top: drives sets through the statistics unit and gives the verdict.
`default_nettype none
module weighted_min_max_mean_variance_unit_tb
   import wmmmv_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT = 20000;  // cycles with no word moving anywhere
   localparam int SETTLE      = 200;    // covers the longest non-result wind-down

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic [DATA_W-1:0] req_value;
   logic [DATA_W-1:0] req_weight;
   logic              req_carries_value;
   logic              req_ends_set;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [DATA_W-1:0] rsp_minimum;
   logic [DATA_W-1:0] rsp_maximum;
   logic [DATA_W-1:0] rsp_mean;
   logic [DATA_W-1:0] rsp_variance;
   logic              rsp_set_empty;
   logic              csr_valid;
   logic              csr_ready;
   logic              csr_use_weights;

   int fail_count;
   int stats_pending;
   int stats_checked;
   int send_idle_pct;
   int recv_idle_pct;
   int values_sent;
   int sets_sent;
   int quiet_cycles = 0;

   always #5 clock = ~clock;

   weighted_min_max_mean_variance_unit u_dut (
      .clock, .reset,
      .req_valid, .req_ready, .req_value, .req_weight, .req_carries_value, .req_ends_set,
      .rsp_valid, .rsp_ready, .rsp_minimum, .rsp_maximum, .rsp_mean, .rsp_variance,
      .rsp_set_empty,
      .csr_valid, .csr_ready, .csr_use_weights
   );

   weighted_min_max_mean_variance_checker u_checker (
      .clock, .reset,
      .req_valid, .req_ready, .req_value, .req_weight, .req_carries_value, .req_ends_set,
      .rsp_valid, .rsp_ready, .rsp_minimum, .rsp_maximum, .rsp_mean, .rsp_variance,
      .rsp_set_empty,
      .csr_valid, .csr_ready, .csr_use_weights,
      .fail_count, .stats_pending, .stats_checked
   );

   // Receiver: stall at random at the current rate
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Watchdog: end the run if nothing moves for too long
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Send one input word; hold valid high across back-to-back words
   task automatic send_word(bit [31:0] v, bit [31:0] w, bit carries, bit ends);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid         <= 1'b1;
      req_value         <= v;
      req_weight        <= w;
      req_carries_value <= carries;
      req_ends_set      <= ends;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (carries) values_sent++;
      if (ends) sets_sent++;
   endtask

   // Drop valid and wait until every set has answered, then let the block settle
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      @(posedge clock);
      while (stats_pending != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_weight_mode(bit on);
      drain();
      csr_valid       <= 1'b1;
      csr_use_weights <= on;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic bit [31:0] pick_value();
      case ($urandom_range(4))
         0:       return $urandom();
         1:       return $urandom_range(32'h000F_FFFF);
         2:       return TOP32 - $urandom_range(32'hFFFF);
         3:       return $urandom_range(1) ? TOP32 : 32'h0;
         default: return 32'h0010_0000 + $urandom_range(32'h3_FFFF);
      endcase
   endfunction

   function automatic bit [31:0] pick_weight();
      case ($urandom_range(5))
         0:       return $urandom();
         1:       return 32'h0;
         2:       return ONE_Q16;
         3:       return TOP32;
         default: return $urandom_range(32'h0004_0000);
      endcase
   endfunction

   // One set of n values with random content, some noise words mixed in
   task automatic send_set(int n);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(9) == 0) send_word($urandom(), $urandom(), 1'b0, 1'b0);
         if (i == n - 1 && $urandom_range(3) != 0)
            send_word(pick_value(), pick_weight(), 1'b1, 1'b1);
         else
            send_word(pick_value(), pick_weight(), 1'b1, 1'b0);
      end
      // close with a bare set end unless the last value already did
      if (n == 0 || !req_ends_set) send_word($urandom(), $urandom(), 1'b0, 1'b1);
   endtask

   task automatic random_phase(int quota);
      int start;
      start = values_sent;
      while (values_sent - start < quota) begin
         if ($urandom_range(15) == 0) send_set(0);
         else send_set($urandom_range(1, 8));
      end
   endtask

   initial begin
      reset             <= 1'b1;
      req_valid         <= 1'b0;
      req_value         <= '0;
      req_weight        <= '0;
      req_carries_value <= 1'b0;
      req_ends_set      <= 1'b0;
      csr_valid         <= 1'b0;
      csr_use_weights   <= 1'b1;
      send_idle_pct = 27;
      recv_idle_pct = 78;
      values_sent   = 0;
      sets_sent     = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_weight_mode(1'b1);
      // Directed: empty set, bare word, extremes, zero total weight, saturation
      send_word(32'h0, 32'h0, 1'b0, 1'b1);
      send_word(TOP32, TOP32, 1'b0, 1'b0);
      send_word(TOP32, TOP32, 1'b1, 1'b1);
      send_word(32'h0, 32'h0, 1'b1, 1'b1);
      send_word(32'h1234_5678, 32'h0, 1'b1, 1'b0);
      send_word(TOP32, 32'h0, 1'b1, 1'b1);
      send_word(32'h0, TOP32, 1'b1, 1'b0);
      send_word(TOP32, TOP32, 1'b1, 1'b1);
      send_word(32'h0, 32'h1, 1'b1, 1'b0);
      send_word(TOP32, 32'h1, 1'b1, 1'b0);
      send_word(32'h5555_AAAA, ONE_Q16, 1'b1, 1'b0);
      send_word(32'h0, 32'h0, 1'b0, 1'b1);
      send_word(32'hAAAA_5555, TOP32, 1'b1, 1'b0);
      send_word(32'h0001_0000, 32'h0, 1'b1, 1'b1);
      // Hold off until every set has answered, then carry on
      drain();
      random_phase(190);

      write_weight_mode(1'b0);
      send_idle_pct = 78;
      recv_idle_pct = 27;
      send_word(TOP32, 32'h0, 1'b1, 1'b0);
      send_word(32'h0, 32'h0, 1'b1, 1'b1);
      random_phase(190);

      write_weight_mode(1'b1);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_phase(190);
      write_weight_mode(1'b0);
      random_phase(20);
      drain();

      $display("Run covered %0d values in %0d sets, %0d results checked,", values_sent,
               sets_sent, stats_checked);
      $display("both weight modes, empty sets, zero total weight, three stall mixes.");
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule
`default_nettype wire

[sim.f]
src/wmmmv_pkg.sv
src/wmmmv_divider.sv
src/weighted_min_max_mean_variance_unit.sv
tb/weighted_min_max_mean_variance_checker.sv
tb/weighted_min_max_mean_variance_unit_tb.sv
